### sv/pbre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch bend base64 RLE encoder package
// Shared types, character constants, the character building functions and a BCD increment.
// ----------------------------------------------------------------------------
package pbre_pkg;

	localparam int VAL_W      = 12;
	localparam int CHAR_W     = 8;
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int SEG_MAX    = 7;
	localparam int BUF_MAX    = 9;
	localparam int LEN_W      = 4;

	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;

	typedef logic [BCD_W-1:0] pbre_bcd_t;

	// One group of characters: a flushed run or a single value.
	typedef struct packed {
		logic [SEG_MAX-1:0][CHAR_W-1:0] ch;
		logic [LEN_W-1:0]               len;
	} pbre_seg_t;

	// All characters caused by one input beat.
	typedef struct packed {
		logic [BUF_MAX-1:0][CHAR_W-1:0] ch;
		logic [LEN_W-1:0]               len;
		logic                           done;
	} pbre_buf_t;

	function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
		logic [CHAR_W-1:0] i8;
		i8 = {2'b00, idx};
		if (idx < 6'd26) begin
			return CH_UPPER + i8;
		end else if (idx < 6'd52) begin
			return CH_LOWER + i8 - 8'd26;
		end else if (idx < 6'd62) begin
			return CH_ZERO + i8 - 8'd52;
		end else if (idx == 6'd62) begin
			return CH_PLUS;
		end else begin
			return CH_SLASH;
		end
	endfunction

	function automatic pbre_seg_t seg_value(input logic [VAL_W-1:0] v);
		pbre_seg_t s;
		s       = '0;
		s.ch[0] = b64_char(v[11:6]);
		s.ch[1] = b64_char(v[5:0]);
		s.len   = 4'd2;
		return s;
	endfunction

	// A run of zero repeats sends nothing, one repeat sends the value again,
	// and longer runs send the decimal count between two hash marks.
	function automatic pbre_seg_t seg_flush(input pbre_bcd_t bcd, input logic [VAL_W-1:0] v);
		pbre_seg_t  s;
		logic [2:0] nd;
		s  = '0;
		nd = 3'd0;
		for (int j = 0; j < BCD_DIGITS; j++) begin
			if (bcd[4*j +: 4] != 4'd0) begin
				nd = 3'(j + 1);
			end
		end
		if (bcd == '0) begin
			s.len = 4'd0;
		end else if (bcd == BCD_W'(1)) begin
			s = seg_value(v);
		end else begin
			s.ch[0] = CH_HASH;
			for (int p = 1; p < SEG_MAX; p++) begin
				for (int j = 0; j < BCD_DIGITS; j++) begin
					if (p <= int'(nd) && j == int'(nd) - p) begin
						s.ch[p] = CH_ZERO + {4'b0000, bcd[4*j +: 4]};
					end
				end
				if (p == int'(nd) + 1) begin
					s.ch[p] = CH_HASH;
				end
			end
			s.len = {1'b0, nd} + 4'd2;
		end
		return s;
	endfunction

	function automatic pbre_bcd_t bcd_inc(input pbre_bcd_t bcd);
		pbre_bcd_t  r;
		logic       c;
		logic [3:0] d;
		r = '0;
		c = 1'b1;
		for (int j = 0; j < BCD_DIGITS; j++) begin
			d = bcd[4*j +: 4];
			if (c && d == 4'd9) begin
				r[4*j +: 4] = 4'd0;
			end else if (c) begin
				r[4*j +: 4] = d + 4'd1;
				c = 1'b0;
			end else begin
				r[4*j +: 4] = d;
			end
		end
		return r;
	endfunction

endpackage

### sv/pbre_pitch_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch reading channel
// Valid/ready channel that carries one pitch reading per beat.
// ----------------------------------------------------------------------------
interface pbre_pitch_if;
	logic        valid;
	logic        ready;
	logic [11:0] pitch_value;
	logic        undefined;
	logic        end_of_stream;

	modport source (output valid, output pitch_value, output undefined,
		output end_of_stream, input ready);
	modport sink (input valid, input pitch_value, input undefined,
		input end_of_stream, output ready);
endinterface

### sv/pbre_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one encoded character per beat.
// ----------------------------------------------------------------------------
interface pbre_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_of_item;
	logic       stream_done;

	modport source (output valid, output out_char, output last_of_item,
		output stream_done, input ready);
	modport sink (input valid, input out_char, input last_of_item,
		input stream_done, output ready);
endinterface

### sv/pbre_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character serializer
// Two-entry character buffer that sends one character per output beat.
// ----------------------------------------------------------------------------
module pbre_serializer
	import pbre_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	output logic               load_ready,
	input  pbre_buf_t          load_buf,
	pbre_char_if.source        char_out
);

	logic             pend_valid_q;
	pbre_buf_t        pend_buf_q;
	logic             ser_valid_q;
	pbre_buf_t        ser_buf_q;
	logic [LEN_W-1:0] ser_idx_q;

	logic last_beat;
	logic out_fire;
	logic ser_free;
	logic move;
	logic load_direct;
	logic load_pend;

	assign last_beat   = (ser_idx_q == ser_buf_q.len - 4'd1);
	assign out_fire    = ser_valid_q && char_out.ready;
	assign ser_free    = !ser_valid_q || (out_fire && last_beat);
	assign move        = pend_valid_q && ser_free;
	assign load_ready  = !pend_valid_q;
	assign load_direct = load_valid && !pend_valid_q && ser_free;
	assign load_pend   = load_valid && load_ready && !load_direct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			ser_valid_q  <= 1'b0;
			ser_idx_q    <= '0;
		end else begin
			if (load_pend) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move || load_direct) begin
				ser_valid_q <= 1'b1;
				ser_idx_q   <= '0;
			end else if (out_fire) begin
				if (last_beat) begin
					ser_valid_q <= 1'b0;
				end else begin
					ser_idx_q <= ser_idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			pend_buf_q <= load_buf;
		end
		if (move) begin
			ser_buf_q <= pend_buf_q;
		end else if (load_direct) begin
			ser_buf_q <= load_buf;
		end
	end

	assign char_out.valid        = ser_valid_q;
	assign char_out.out_char     = ser_buf_q.ch[ser_idx_q];
	assign char_out.last_of_item = last_beat;
	assign char_out.stream_done  = last_beat && ser_buf_q.done;

endmodule

### sv/pitch_bend_base64_rle_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch bend base64 run-length encoder
// Turns a stream of 12-bit pitch readings into base64 text with repeat runs.
// ----------------------------------------------------------------------------
// Each accepted reading beat immediately updates the encoder state; a reading
// that only extends a run produces no characters and the next beat can follow
// in the very next cycle. A reading that produces characters (two to nine of
// them) hands them to a two-entry character buffer, which sends one character
// per output beat. The output side therefore sets the sustained rate: an item
// that emits n characters occupies the output for n beats, and the input keeps
// accepting until one full group of characters waits behind the group being
// sent.
// ----------------------------------------------------------------------------
module pitch_bend_base64_rle_encoder_top
	import pbre_pkg::*;
#(
	parameter int MAX_POINTS = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	pbre_pitch_if.sink   pitch_in,
	pbre_char_if.source  char_out
);

	// The binary run count only needs to reach MAX_POINTS - 1. A decimal copy
	// of the same count is kept alongside it, so a flush needs no division.
	localparam int               CNT_W     = $clog2(MAX_POINTS);
	localparam logic [CNT_W-1:0] RUN_LIMIT = CNT_W'(MAX_POINTS - 1);

	logic [VAL_W-1:0] prev_q;
	logic             prev_valid_q;
	logic [CNT_W-1:0] count_q;
	pbre_bcd_t        bcd_q;

	logic             in_fire;
	logic             load_ready;
	logic             load_valid;
	logic [VAL_W-1:0] cur;
	logic             match;
	logic             at_limit;
	pbre_seg_t        seg1;
	pbre_seg_t        seg2;
	pbre_buf_t        plan;
	logic [CNT_W-1:0] count_next;
	pbre_bcd_t        bcd_next;

	assign in_fire        = pitch_in.valid && pitch_in.ready;
	assign pitch_in.ready = load_ready;

	assign cur      = pitch_in.undefined ? '0 : pitch_in.pitch_value;
	assign match    = prev_valid_q && (cur == prev_q);
	assign at_limit = (count_q == RUN_LIMIT);

	// A changed reading flushes the pending run of the old value, then sends
	// itself. A repeat only grows the run, unless the run is full, in which
	// case the full run is flushed first and a new run of one begins. At the
	// end of a stream the pending run is flushed after the reading.
	always_comb begin
		seg1       = '0;
		seg2       = '0;
		count_next = count_q;
		bcd_next   = bcd_q;
		if (match) begin
			if (at_limit) begin
				seg1       = seg_flush(bcd_q, prev_q);
				count_next = CNT_W'(1);
				bcd_next   = BCD_W'(1);
			end else begin
				count_next = count_q + CNT_W'(1);
				bcd_next   = bcd_inc(bcd_q);
			end
			if (pitch_in.end_of_stream) begin
				seg2 = seg_flush(bcd_next, cur);
			end
		end else begin
			seg1       = seg_flush(bcd_q, prev_q);
			seg2       = seg_value(cur);
			count_next = '0;
			bcd_next   = '0;
		end
	end

	// Pack the two groups back to back into one character buffer.
	always_comb begin
		plan      = '0;
		plan.len  = seg1.len + seg2.len;
		plan.done = pitch_in.end_of_stream;
		for (int i = 0; i < SEG_MAX; i++) begin
			if (4'(i) < seg1.len) begin
				plan.ch[i] = seg1.ch[i];
			end
		end
		for (int i = 0; i < BUF_MAX; i++) begin
			for (int j = 0; j < SEG_MAX; j++) begin
				if (4'(i) >= seg1.len && 4'(i) - seg1.len == 4'(j)) begin
					plan.ch[i] = seg2.ch[j];
				end
			end
		end
	end

	assign load_valid = in_fire && (plan.len != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			count_q      <= '0;
			bcd_q        <= '0;
		end else if (in_fire) begin
			if (pitch_in.end_of_stream) begin
				prev_q       <= '0;
				prev_valid_q <= 1'b0;
				count_q      <= '0;
				bcd_q        <= '0;
			end else begin
				prev_q       <= cur;
				prev_valid_q <= 1'b1;
				count_q      <= count_next;
				bcd_q        <= bcd_next;
			end
		end
	end

	pbre_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (load_valid),
		.load_ready (load_ready),
		.load_buf   (plan),
		.char_out   (char_out)
	);

endmodule

### sv/pbre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder port checker
// Concurrent checks on the character output of the encoder, bound to the top.
// ----------------------------------------------------------------------------
module pbre_checker
	import pbre_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       last_of_item,
	input logic       stream_done
);

	// The end of a stream always closes the characters of its reading.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_item)
		else $error("stream_done without last_of_item");

	// The characters of one reading go out without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_item |=> out_valid)
		else $error("gap inside the characters of one reading");

	// The padding character is never part of the encoding.
	a_no_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_char != CH_PAD)
		else $error("padding character emitted");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
		&& $stable(last_of_item) && $stable(stream_done))
		else $error("stalled output beat changed");

endmodule

bind pitch_bend_base64_rle_encoder_top pbre_checker u_pbre_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (char_out.valid),
	.out_ready    (char_out.ready),
	.out_char     (char_out.out_char),
	.last_of_item (char_out.last_of_item),
	.stream_done  (char_out.stream_done)
);
